[rtl/integer_to_ascii_formatter_assert.svh]
// Assertion macros used by the checker file.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Condition must hold on every enabled edge.
`define ITAF_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define ITAF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent on the following edge.
`define ITAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/itaf_pkg.sv]
`default_nettype none

package itaf_pkg;

   // operand and digit store sizes
   localparam int MAG_W      = 32;
   localparam int DIGITS_MAX = 10;
   localparam int BCD_W      = 4 * DIGITS_MAX;
   localparam int CNT_W      = 5;

   localparam logic [3:0] RUN_LEN_MAX = 4'd11;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_LOW_A = 8'h61;
   localparam logic [7:0] ASCII_MINUS = 8'h2d;

   typedef enum logic [1:0] {
      KIND_SDEC = 2'd0,
      KIND_UDEC = 2'd1,
      KIND_HEX  = 2'd2,
      KIND_CHAR = 2'd3
   } kind_type;

   // one nibble to its lowercase hex / decimal glyph
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = ASCII_ZERO + {4'h0, d};
      end else begin
         r = ASCII_LOW_A + {4'h0, d} - 8'd10;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/integer_to_ascii_formatter.sv]
// Flow: a character item goes straight to the output register; a hex item goes through the
//   leading-zero scan; a decimal item runs the 32-step shift-add-3 loop, then the scan,
//   which drops leading zero digits before the first beat.
// One item at a time; the run (1 to 11 beats) goes out at one beat per cycle while
//   rsp_tready is high.
// Reset: synchronous, active high; clears state and rsp_tvalid, ready again next cycle.
`default_nettype none

module integer_to_ascii_formatter
   import itaf_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire  [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] character, [11:8] run_length, [15:12] zero
   output logic        rsp_tlast    // last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,   // bit-serial binary to BCD
      ST_SCAN,   // drop leading zero digits
      ST_EMIT    // one beat per character
   } state_type;

   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [BCD_W-1:0] bcd_adj;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       ndig_ff, ndig_in;
   logic [3:0]       remain_ff, remain_in;
   logic [3:0]       len_ff, len_in;
   logic [3:0]       len_sum;
   logic [3:0]       top_dig;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;
   logic             neg_ff, neg_in;   // minus still to be sent
   kind_type         req_kind;

   assign req_kind = kind_type'(req_tuser);
   assign top_dig  = bcd_ff[BCD_W-1 -: 4];
   assign len_sum  = ndig_ff + {3'b000, neg_ff};

   // add 3 to every BCD digit of 5 or more before the next shift
   always_comb begin
      for (int i = 0; i < DIGITS_MAX; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      ndig_in      = ndig_ff;
      remain_in    = remain_ff;
      len_in       = len_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      neg_in       = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  KIND_CHAR: begin
                     char_in      = req_tdata[7:0];
                     last_in      = 1'b1;
                     len_in       = 4'd1;
                     remain_in    = 4'd0;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_EMIT;
                  end
                  KIND_HEX: begin
                     // nibbles are the digits already; top two stay zero
                     bcd_in   = {{(BCD_W-MAG_W){1'b0}}, req_tdata};
                     neg_in   = 1'b0;
                     ndig_in  = 4'(DIGITS_MAX);
                     state_in = ST_SCAN;
                  end
                  default: begin
                     neg_in   = (req_kind == KIND_SDEC) && req_tdata[MAG_W-1];
                     mag_in   = ((req_kind == KIND_SDEC) && req_tdata[MAG_W-1]) ?
                                (~req_tdata + 32'd1) : req_tdata;
                     bcd_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_CONV;
                  end
               endcase
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[MAG_W-1]};
            mag_in = {mag_ff[MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W-1)) begin
               ndig_in  = 4'(DIGITS_MAX);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((top_dig == 4'd0) && (ndig_ff != 4'd1)) begin
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'h0};
               ndig_in = ndig_ff - 1'b1;
            end else begin
               len_in       = len_sum;
               remain_in    = len_sum - 1'b1;
               last_in      = (len_sum == 4'd1);
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT;
               if (neg_ff) begin
                  char_in = ASCII_MINUS;
                  neg_in  = 1'b0;
               end else begin
                  char_in = digit_char(top_dig);
                  bcd_in  = {bcd_ff[BCD_W-5:0], 4'h0};
               end
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (last_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  char_in   = digit_char(top_dig);
                  bcd_in    = {bcd_ff[BCD_W-5:0], 4'h0};
                  remain_in = remain_ff - 1'b1;
                  last_in   = (remain_ff == 4'd1);
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      bcd_ff    <= bcd_in;
      cnt_ff    <= cnt_in;
      ndig_ff   <= ndig_in;
      remain_ff <= remain_in;
      len_ff    <= len_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      neg_ff    <= neg_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, len_ff, char_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

[rtl/itaf_check.sv]
`default_nettype none

`include "integer_to_ascii_formatter_assert.svh"

module itaf_check
   import itaf_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata,
   input wire        rsp_tlast
);

   logic req_beat, rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // stalled result beat holds
   `ITAF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp beat changed while stalled")

   // run length in range, padding zero
   `ITAF_ASSERT_SAME(a_len_range, clock, reset, rsp_tvalid, (rsp_tdata[11:8] != 4'd0) && (rsp_tdata[11:8] <= RUN_LEN_MAX) && (rsp_tdata[15:12] == 4'd0), "run length out of range")

   // a run continues without gaps and keeps its length
   `ITAF_ASSERT_NEXT(a_run_cont, clock, reset, rsp_beat && !rsp_tlast, rsp_tvalid && $stable(rsp_tdata[11:8]), "run broken or length changed")

   // one item in flight
   `ITAF_ASSERT_NEXT(a_one_item, clock, reset, req_beat, !req_tready, "input taken while busy")

   `ITAF_ASSERT_HOLDS(a_no_overlap, clock, reset, !(rsp_tvalid && req_tready), "input ready during a run")

endmodule

bind integer_to_ascii_formatter itaf_check u_itaf_check (.*);

`default_nettype wire
